>>> hdl/lcps_pkg.sv
// ----------------------------------------------------------------------------
// lcps_pkg
// Shared types and constants for the line centroid PD steering block.
// ----------------------------------------------------------------------------
package lcps_pkg;

  localparam int SENSOR_W   = 10;
  localparam int SUM_W      = 12;
  localparam int NUM_W      = 13;
  localparam int DIVIDEND_W = 23;
  localparam int QUOT_W     = 12;
  localparam int ERR_W      = 12;
  localparam int GAIN_W     = 10;
  localparam int SPEED_W    = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 10;
  localparam int ACC_W      = 26;

  localparam int GAIN_FRAC_BITS_DEF = 8;

  localparam logic [GAIN_W-1:0]  GAIN_P_RST     = 10'd77;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST     = 10'd26;
  localparam logic [SPEED_W-1:0] BASE_SPEED_RST = 8'd180;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST  = 8'd255;
  localparam logic [SPEED_W-1:0] DEADBAND_RST   = 8'd10;

  localparam logic [QUOT_W-1:0] CENTRE_OFFSET = 12'd2048;

  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_P     = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_GAIN_D     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_SPEED = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_SPEED  = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND   = 3'd4;

  typedef struct packed {
    logic [SENSOR_W-1:0] sensor_left;
    logic [SENSOR_W-1:0] sensor_center;
    logic [SENSOR_W-1:0] sensor_right;
  } in_t;

  typedef struct packed {
    logic [SPEED_W-1:0]      speed_left;
    logic [SPEED_W-1:0]      speed_right;
    logic signed [ERR_W-1:0] line_error;
    logic                    no_line;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL_P,
    ST_MUL_D,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIVIDEND_W-1:0] dividend;
    logic [SUM_W-1:0]      divisor;
  } div_ctl_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quotient;
  } div_sts_t;

endpackage

>>> hdl/lcps_div.sv
// ----------------------------------------------------------------------------
// lcps_div
// Restoring divider, one quotient bit per cycle. The quotient is known to
// fit in QUOT_W bits, so the upper dividend bits seed the remainder.
// ----------------------------------------------------------------------------
module lcps_div (
  input  logic              clk,
  input  logic              rst_n,
  input  lcps_pkg::div_ctl_t ctl,
  output lcps_pkg::div_sts_t sts
);

  localparam int QW = lcps_pkg::QUOT_W;
  localparam int SW = lcps_pkg::SUM_W;
  localparam int CW = $clog2(QW);
  localparam logic [CW-1:0] LAST = CW'(QW - 1);

  logic          busy_r, busy_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [QW-1:0] low_r, low_nxt;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [SW-1:0] div_r, div_nxt;
  logic          done_r, done_nxt;
  logic [SW:0]   shifted;
  logic [SW:0]   trial;

  assign shifted = {rem_r, low_r[QW-1]};
  assign trial   = shifted - {1'b0, div_r};

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = SW'(ctl.dividend[lcps_pkg::DIVIDEND_W-1:QW]);
      low_nxt  = ctl.dividend[QW-1:0];
      div_nxt  = ctl.divisor;
    end else if (busy_r) begin
      low_nxt = {low_r[QW-2:0], 1'b0};
      if (!trial[SW]) begin
        rem_nxt = trial[SW-1:0];
        quo_nxt = {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[SW-1:0];
        quo_nxt = {quo_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + CW'(1);
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign sts.done     = done_r;
  assign sts.quotient = quo_r;

endmodule

>>> hdl/line_centroid_pd_steering.sv
// ----------------------------------------------------------------------------
// line_centroid_pd_steering
// Three-sensor line centroid and PD steering controller.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries three sensor samples.
//   Output channel out_valid/out_stall/out_data carries both wheel speeds,
//   the centroid error and the no-line flag, one item per input item.
//   Configuration is written through cfg_we/cfg_addr/cfg_wdata while idle.
// Timing:
//   An accepted item runs the serial divider, one quotient bit per cycle,
//   then two passes through the shared multiplier and a finishing state
//   before its result is shown. A zero sensor sum skips the arithmetic and
//   is shown in the next cycle.
//   in_stall stays high from acceptance until the result item is taken.
// Reset:
//   rst_n is synchronous; it returns the sequencer to idle, drops out_valid,
//   clears the previous error and restores the register reset values.
// Back-pressure:
//   A stalled result item holds unchanged and no new item is taken.
// ----------------------------------------------------------------------------
module line_centroid_pd_steering #(
  parameter int GAIN_FRAC_BITS = lcps_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  lcps_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output lcps_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [lcps_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [lcps_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW = lcps_pkg::ACC_W;
  localparam int EW = lcps_pkg::ERR_W;
  localparam int SPW = lcps_pkg::SPEED_W;
  localparam logic [AW-1:0] ROUND_BIAS = AW'((1 << GAIN_FRAC_BITS) - 1);

  lcps_pkg::state_t state_r, state_nxt;

  logic [lcps_pkg::GAIN_W-1:0] gain_p_r, gain_d_r;
  logic [SPW-1:0]              base_r, max_r, dband_r;

  logic signed [EW-1:0] err_r, last_r;
  logic signed [AW-1:0] acc_r;
  lcps_pkg::out_t       out_r;

  logic                 accept;
  logic [lcps_pkg::SUM_W-1:0] sum;
  logic [lcps_pkg::NUM_W-1:0] num;
  logic                 div_start;
  lcps_pkg::div_ctl_t   div_ctl;
  lcps_pkg::div_sts_t   div_sts;

  logic                 sel_d;
  logic signed [10:0]   mul_a;
  logic signed [13:0]   mul_b;
  logic signed [24:0]   prod;
  logic signed [EW:0]   diff;

  logic signed [AW-1:0] biased, drive, mag, left_v, right_v;
  logic signed [AW-1:0] max_ext;
  logic [SPW-1:0]       left_c, right_c;

  assign accept = in_valid && !in_stall;

  assign sum = lcps_pkg::SUM_W'(in_data.sensor_left) + lcps_pkg::SUM_W'(in_data.sensor_center)
             + lcps_pkg::SUM_W'(in_data.sensor_right);
  assign num = lcps_pkg::NUM_W'(in_data.sensor_left)
             + lcps_pkg::NUM_W'({in_data.sensor_center, 1'b0})
             + lcps_pkg::NUM_W'({in_data.sensor_right, 1'b0})
             + lcps_pkg::NUM_W'(in_data.sensor_right);

  assign div_ctl.start    = div_start;
  assign div_ctl.dividend = {num, 10'b0};
  assign div_ctl.divisor  = sum;

  lcps_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (div_ctl),
    .sts   (div_sts)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lcps_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (sum == '0) ? lcps_pkg::ST_OUT : lcps_pkg::ST_DIV;
        end
      end
      lcps_pkg::ST_DIV: begin
        if (div_sts.done) begin
          state_nxt = lcps_pkg::ST_MUL_P;
        end
      end
      lcps_pkg::ST_MUL_P: state_nxt = lcps_pkg::ST_MUL_D;
      lcps_pkg::ST_MUL_D: state_nxt = lcps_pkg::ST_FIN;
      lcps_pkg::ST_FIN:   state_nxt = lcps_pkg::ST_OUT;
      lcps_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_nxt = lcps_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lcps_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    div_start = 1'b0;
    sel_d     = 1'b0;
    unique case (state_r)
      lcps_pkg::ST_IDLE: begin
        in_stall  = 1'b0;
        div_start = accept && (sum != '0);
      end
      lcps_pkg::ST_MUL_D: sel_d = 1'b1;
      lcps_pkg::ST_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  // shared multiplier
  assign diff  = {err_r[EW-1], err_r} - {last_r[EW-1], last_r};
  assign mul_a = $signed({1'b0, sel_d ? gain_d_r : gain_p_r});
  assign mul_b = sel_d ? 14'(diff) : 14'(err_r);
  assign prod  = mul_a * mul_b;

  // truncate toward zero, then steer and clamp
  assign biased  = acc_r + (acc_r[AW-1] ? $signed(ROUND_BIAS) : $signed(AW'(0)));
  assign drive   = biased >>> GAIN_FRAC_BITS;
  assign mag     = drive[AW-1] ? -drive : drive;
  assign max_ext = $signed(AW'(max_r));
  assign left_v  = $signed(AW'(base_r)) + drive;
  assign right_v = $signed(AW'(base_r)) - drive;

  always_comb begin
    if (left_v > max_ext) begin
      left_c = max_r;
    end else if (left_v[AW-1]) begin
      left_c = '0;
    end else begin
      left_c = left_v[SPW-1:0];
    end
    if (right_v > max_ext) begin
      right_c = max_r;
    end else if (right_v[AW-1]) begin
      right_c = '0;
    end else begin
      right_c = right_v[SPW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= lcps_pkg::ST_IDLE;
      gain_p_r <= lcps_pkg::GAIN_P_RST;
      gain_d_r <= lcps_pkg::GAIN_D_RST;
      base_r   <= lcps_pkg::BASE_SPEED_RST;
      max_r    <= lcps_pkg::MAX_SPEED_RST;
      dband_r  <= lcps_pkg::DEADBAND_RST;
      last_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          lcps_pkg::REG_GAIN_P:     gain_p_r <= cfg_wdata;
          lcps_pkg::REG_GAIN_D:     gain_d_r <= cfg_wdata;
          lcps_pkg::REG_BASE_SPEED: base_r   <= cfg_wdata[SPW-1:0];
          lcps_pkg::REG_MAX_SPEED:  max_r    <= cfg_wdata[SPW-1:0];
          lcps_pkg::REG_DEADBAND:   dband_r  <= cfg_wdata[SPW-1:0];
          default: ;
        endcase
      end
      if (state_r == lcps_pkg::ST_IDLE && accept && sum == '0) begin
        last_r <= '0;
      end else if (state_r == lcps_pkg::ST_FIN) begin
        last_r <= err_r;
      end
    end

    if (state_r == lcps_pkg::ST_IDLE && accept && sum == '0) begin
      out_r.speed_left  <= max_r;
      out_r.speed_right <= max_r;
      out_r.line_error  <= '0;
      out_r.no_line     <= 1'b1;
    end
    if (state_r == lcps_pkg::ST_DIV && div_sts.done) begin
      err_r <= $signed(div_sts.quotient - lcps_pkg::CENTRE_OFFSET);
    end
    if (state_r == lcps_pkg::ST_MUL_P) begin
      acc_r <= AW'(prod);
    end else if (state_r == lcps_pkg::ST_MUL_D) begin
      acc_r <= acc_r + AW'(prod);
    end
    if (state_r == lcps_pkg::ST_FIN) begin
      if (mag < $signed(AW'(dband_r))) begin
        out_r.speed_left  <= max_r;
        out_r.speed_right <= max_r;
      end else begin
        out_r.speed_left  <= left_c;
        out_r.speed_right <= right_c;
      end
      out_r.line_error <= err_r;
      out_r.no_line    <= 1'b0;
    end
  end

  assign out_data = out_r;

endmodule

>>> hdl/lcps_chk.sv
// ----------------------------------------------------------------------------
// lcps_chk
// Port-level checks for the line centroid PD steering block.
// ----------------------------------------------------------------------------
module lcps_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            out_valid,
  input logic                            out_stall,
  input lcps_pkg::out_t                  out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result item dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("stalled result item changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("new item taken while previous item in flight");

  a_no_take_while_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result item pending");

  a_no_line_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.no_line |-> out_data.line_error == '0 &&
      out_data.speed_left == out_data.speed_right)
    else $error("no-line item carries steering");

endmodule

bind line_centroid_pd_steering lcps_chk u_lcps_chk (.*);

>>> dv/line_centroid_pd_steering_chk.sv
// ----------------------------------------------------------------------------
// line_centroid_pd_steering_chk
// Watches the input, result and register ports of the steering block. It
// keeps its own copy of the registers and the previous error, predicts the
// wheel speeds, error and no-line flag for every item taken in, and compares
// each result item taken out against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module line_centroid_pd_steering_chk #(
  parameter int FRAC_BITS = lcps_pkg::GAIN_FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  lcps_pkg::in_t                   in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  lcps_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [lcps_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [lcps_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                              errors,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [lcps_pkg::GAIN_W-1:0]  gain_p;
  logic [lcps_pkg::GAIN_W-1:0]  gain_d;
  logic [lcps_pkg::SPEED_W-1:0] base_spd;
  logic [lcps_pkg::SPEED_W-1:0] max_spd;
  logic [lcps_pkg::SPEED_W-1:0] dead_band;
  longint                       prev_err;
  lcps_pkg::out_t               steer_q [$];
  lcps_pkg::out_t               want;

  function automatic logic [lcps_pkg::SPEED_W-1:0] speed_clamp(input longint v);
    if (v > longint'(max_spd)) return max_spd;
    if (v < 0) return '0;
    return lcps_pkg::SPEED_W'(v);
  endfunction

  function automatic lcps_pkg::out_t steer_predict(input lcps_pkg::in_t s);
    logic [lcps_pkg::SUM_W-1:0] total;
    logic [lcps_pkg::NUM_W-1:0] moment;
    longint                     err;
    longint                     drive;
    longint                     mag;
    lcps_pkg::out_t             r;
    total  = s.sensor_left + s.sensor_center + s.sensor_right;
    moment = lcps_pkg::NUM_W'(s.sensor_left + 2 * s.sensor_center + 3 * s.sensor_right);
    r = '0;
    if (total == 0) begin
      prev_err      = 0;
      r.speed_left  = max_spd;
      r.speed_right = max_spd;
      r.no_line     = 1'b1;
      return r;
    end
    err   = (longint'(moment) * 1024) / longint'(total) - 2048;
    drive = longint'(gain_p) * err + longint'(gain_d) * (err - prev_err);
    drive = drive / (longint'(1) << FRAC_BITS);
    prev_err = err;
    mag = (drive < 0) ? -drive : drive;
    if (mag < longint'(dead_band)) begin
      r.speed_left  = max_spd;
      r.speed_right = max_spd;
    end else begin
      r.speed_left  = speed_clamp(longint'(base_spd) + drive);
      r.speed_right = speed_clamp(longint'(base_spd) - drive);
    end
    r.line_error = err[lcps_pkg::ERR_W-1:0];
    return r;
  endfunction

  initial begin
    errors  = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      gain_p    = lcps_pkg::GAIN_P_RST;
      gain_d    = lcps_pkg::GAIN_D_RST;
      base_spd  = lcps_pkg::BASE_SPEED_RST;
      max_spd   = lcps_pkg::MAX_SPEED_RST;
      dead_band = lcps_pkg::DEADBAND_RST;
      prev_err  = 0;
      steer_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (steer_q.size() == 0) begin
          $error("result item with no prediction waiting: %p", out_data);
          errors++;
        end else begin
          want = steer_q.pop_front();
          if (out_data.speed_left !== want.speed_left) begin
            $error("speed_left: expected %0d, got %0d", want.speed_left,
                   out_data.speed_left);
            errors++;
          end
          if (out_data.speed_right !== want.speed_right) begin
            $error("speed_right: expected %0d, got %0d", want.speed_right,
                   out_data.speed_right);
            errors++;
          end
          if (out_data.line_error !== want.line_error) begin
            $error("line_error: expected %0d, got %0d", want.line_error,
                   out_data.line_error);
            errors++;
          end
          if (out_data.no_line !== want.no_line) begin
            $error("no_line: expected %0d, got %0d", want.no_line,
                   out_data.no_line);
            errors++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          lcps_pkg::REG_GAIN_P:     gain_p    = cfg_wdata[lcps_pkg::GAIN_W-1:0];
          lcps_pkg::REG_GAIN_D:     gain_d    = cfg_wdata[lcps_pkg::GAIN_W-1:0];
          lcps_pkg::REG_BASE_SPEED: base_spd  = cfg_wdata[lcps_pkg::SPEED_W-1:0];
          lcps_pkg::REG_MAX_SPEED:  max_spd   = cfg_wdata[lcps_pkg::SPEED_W-1:0];
          lcps_pkg::REG_DEADBAND:   dead_band = cfg_wdata[lcps_pkg::SPEED_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        steer_q.push_back(steer_predict(in_data));
      end
    end
    pending = steer_q.size();
  end

endmodule

>>> dv/line_centroid_pd_steering_tb.sv
// ----------------------------------------------------------------------------
// line_centroid_pd_steering_tb
// Drives sensor items into the steering block: a directed set of edge cases
// under reset settings, then random items across register settings that
// include the extremes, with idle and stall phases on both channels. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module line_centroid_pd_steering_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [lcps_pkg::CFG_ADDR_W-1:0] REG_IDS [5] = '{
    lcps_pkg::REG_GAIN_P, lcps_pkg::REG_GAIN_D, lcps_pkg::REG_BASE_SPEED,
    lcps_pkg::REG_MAX_SPEED, lcps_pkg::REG_DEADBAND
  };

  localparam int CFG_EXTREMES [5][5] = '{
    '{1023, 1023, 255, 255,   0},
    '{   0,    0,   0,   0, 255},
    '{  77,   26, 200, 120,  10},
    '{1023,    0, 128, 255, 255},
    '{   0, 1023,  60, 200,   1}
  };

  localparam int SND_IDLE  [4] = '{0, 75,  0, 18};
  localparam int RCV_STALL [4] = '{0,  0, 75, 18};

  localparam lcps_pkg::in_t EDGE_ITEMS [17] = '{
    '{10'd0,    10'd0,    10'd0},
    '{10'd1023, 10'd0,    10'd0},
    '{10'd0,    10'd0,    10'd1023},
    '{10'd0,    10'd0,    10'd0},
    '{10'd0,    10'd0,    10'd1023},
    '{10'd0,    10'd1023, 10'd0},
    '{10'd1023, 10'd1023, 10'd1023},
    '{10'd1,    10'd0,    10'd0},
    '{10'd0,    10'd1,    10'd0},
    '{10'd0,    10'd0,    10'd1},
    '{10'd1023, 10'd0,    10'd1023},
    '{10'd512,  10'd512,  10'd520},
    '{10'd512,  10'd512,  10'd500},
    '{10'h2AA,  10'h155,  10'h3FF},
    '{10'h155,  10'h2AA,  10'h000},
    '{10'd700,  10'd300,  10'd0},
    '{10'd0,    10'd300,  10'd700}
  };

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  lcps_pkg::in_t                   in_data;
  logic                            out_valid;
  logic                            out_stall;
  lcps_pkg::out_t                  out_data;
  logic                            cfg_we;
  logic [lcps_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [lcps_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                              fails;
  int                              pending;
  int                              snd_idle = 0;
  int                              rcv_stall = 0;

  line_centroid_pd_steering i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  line_centroid_pd_steering_chk i_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .errors    (fails),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      out_stall <= ($urandom_range(99) < rcv_stall);
    end
  end

  initial begin
    #5_000_000;
    $display("line_centroid_pd_steering_tb: errors");
    $finish;
  end

  function automatic lcps_pkg::in_t rand_sensors();
    lcps_pkg::in_t s;
    int            mid;
    int            pick;
    pick = $urandom_range(15);
    s.sensor_left   = lcps_pkg::SENSOR_W'($urandom_range(1023));
    s.sensor_center = lcps_pkg::SENSOR_W'($urandom_range(1023));
    s.sensor_right  = lcps_pkg::SENSOR_W'($urandom_range(1023));
    if (pick == 0) begin
      s = '0;
    end else if (pick == 1) begin
      case ($urandom_range(2))
        0:       {s.sensor_center, s.sensor_right} = '0;
        1:       {s.sensor_left, s.sensor_right} = '0;
        default: {s.sensor_left, s.sensor_center} = '0;
      endcase
    end else if (pick < 7) begin
      mid = $urandom_range(8, 1015);
      s.sensor_left   = lcps_pkg::SENSOR_W'(mid + $urandom_range(16) - 8);
      s.sensor_center = lcps_pkg::SENSOR_W'(mid + $urandom_range(16) - 8);
      s.sensor_right  = lcps_pkg::SENSOR_W'(mid + $urandom_range(16) - 8);
    end
    return s;
  endfunction

  task automatic send_item(input lcps_pkg::in_t s);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_regs(input int gp, input int gd, input int bs, input int ms,
                          input int db);
    int vals [5];
    vals = '{gp, gd, bs, ms, db};
    drain();
    repeat (4) @(negedge clk);
    for (int i = 0; i < 6; i++) begin
      cfg_we <= 1'b1;
      if (i < 5) begin
        cfg_addr <= REG_IDS[i];
        if (REG_IDS[i] == lcps_pkg::REG_GAIN_P || REG_IDS[i] == lcps_pkg::REG_GAIN_D) begin
          cfg_wdata <= lcps_pkg::CFG_DATA_W'(vals[i]);
        end else begin
          cfg_wdata <= {2'($urandom_range(3)), 8'(vals[i])};
        end
      end else begin
        // index past the last register: must leave every register alone
        cfg_addr  <= lcps_pkg::CFG_ADDR_W'($urandom_range(int'(lcps_pkg::REG_DEADBAND) + 1,
                                                           (1 << lcps_pkg::CFG_ADDR_W) - 1));
        cfg_wdata <= lcps_pkg::CFG_DATA_W'($urandom_range(1023));
      end
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic run_items(input int n);
    for (int k = 0; k < n; k++) begin
      if (k % 64 == 63) drain();
      send_item(rand_sensors());
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_addr  = '0;
    cfg_wdata = '0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (EDGE_ITEMS[k]) send_item(EDGE_ITEMS[k]);

    for (int p = 0; p < 10; p++) begin
      if (p < 5) begin
        set_regs(CFG_EXTREMES[p][0], CFG_EXTREMES[p][1], CFG_EXTREMES[p][2],
                 CFG_EXTREMES[p][3], CFG_EXTREMES[p][4]);
      end else begin
        set_regs($urandom_range(1023), $urandom_range(1023), $urandom_range(255),
                 $urandom_range(255), $urandom_range(40));
      end
      snd_idle  = SND_IDLE[p % 4];
      rcv_stall = RCV_STALL[p % 4];
      run_items(70);
    end

    drain();
    repeat (20) @(negedge clk);
    if (fails == 0) begin
      $display("line_centroid_pd_steering_tb: clean");
    end else begin
      $display("line_centroid_pd_steering_tb: errors");
    end
    $finish;
  end

endmodule
